>>> rtl/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// shared constants for the audio peak limiter: register map, reset values
// ----------------------------------------------------------------------------
`default_nettype none

package apl_pkg;

  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_LIMITER_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_SCALE      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_LEVEL = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_COEF     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_COEF    = 3'd5;

  localparam logic [15:0] RST_PEAK_SCALE   = 16'd32768;
  localparam logic [15:0] RST_THRESHOLD    = 16'd32768;
  localparam logic [15:0] RST_CEILING      = 16'd32768;
  localparam logic [15:0] RST_ATTACK_COEF  = 16'd64188;
  localparam logic [15:0] RST_RELEASE_COEF = 16'd65522;

  localparam logic [16:0] UNITY_Q16 = 17'd65536;
  localparam logic [16:0] FLOOR_Q16 = 17'd6;
  localparam logic [16:0] MAX17     = 17'd131071;

endpackage

`default_nettype wire

>>> rtl/apl_if.sv
// ----------------------------------------------------------------------------
// apl_in_if / apl_out_if
// valid/ready channels carrying limiter sample words in and results out
// ----------------------------------------------------------------------------
`default_nettype none

interface apl_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface apl_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  logic [31:0]                   clip_count;

  modport source (output valid, output sample_out, output clipped, output clip_count,
                  input ready);
  modport sink (input valid, input sample_out, input clipped, input clip_count,
                output ready);
endinterface

`default_nettype wire

>>> rtl/audio_peak_limiter_top.sv
// ----------------------------------------------------------------------------
// audio_peak_limiter_top
// peak limiter with attack/release envelope, smoothed gain and hard clamp
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one signed sample word; out_ch returns one result word per
//   input: limited/clamped sample, clamp flag and saturating clamp count.
//   cfg_we/cfg_index/cfg_data write the six control registers; write them
//   only while the block is idle. unknown indexes are dropped.
// sequencing
//   one shared multiplier (sample-width+1, at least 17, by 17 bits) and a
//   one-bit-per-cycle restoring divider do all the math under a small sequencer.
//   limiter enabled: scale, level, envelope, limit and compare steps, a
//   divide only when the envelope is over the limit and above a floor, then
//   gain smoothing, apply, ceiling and output steps.
//   limiter disabled: scale, ceiling and output steps only.
//   in_ch.ready is high only while idle, so one word is in the sequencer at a time.
// reset
//   synchronous active-high rst restores register defaults, clears the
//   envelope and clamp count, sets unity gain and empties the output.
// stall
//   the result sits in an output register; a new word is taken while it
//   waits, but the next result holds in the sequencer until out_ch drains.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_peak_limiter_top #(
  parameter int SAMPLE_BITS = apl_pkg::DEF_SAMPLE_BITS
) (
  input  wire                                      clk,
  input  wire                                      rst,
  apl_in_if.sink                                   in_ch,
  apl_out_if.source                                out_ch,
  input  wire                                      cfg_we,
  input  wire  [apl_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  wire  [apl_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import apl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  // multiplier operand widths: a holds the scaled magnitude or a q1.16 value
  localparam int MA = (SB + 1 > 17) ? SB + 1 : 17;
  localparam int MW = MA + 17;
  localparam int AW = 35;
  // q.(SB-1) to q.16 conversion
  localparam int QL = (SB <= 17) ? 17 - SB : 0;
  localparam int QR = (SB > 17) ? SB - 17 : 0;
  localparam int QW = MA + QL + 1;
  localparam logic [QW-1:0] QRND = (QR > 0) ? (QW'(1) << (QR - 1)) : '0;
  // q2.30 to sample conversion for the ceiling
  localparam int HL = (SB >= 31) ? SB - 31 : 0;
  localparam int HR = (SB >= 31) ? 0 : 31 - SB;
  localparam int HW = MW + 2;
  localparam logic [HW-1:0] HRND = (HR > 0) ? (HW'(1) << (HR - 1)) : '0;
  localparam int CW = MA + 2;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAG   = 4'd1;
  localparam logic [3:0] S_LEVEL = 4'd2;
  localparam logic [3:0] S_ENV0  = 4'd3;
  localparam logic [3:0] S_ENV1  = 4'd4;
  localparam logic [3:0] S_ENV2  = 4'd5;
  localparam logic [3:0] S_LIM   = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_G0    = 4'd9;
  localparam logic [3:0] S_G1    = 4'd10;
  localparam logic [3:0] S_G2    = 4'd11;
  localparam logic [3:0] S_APPLY = 4'd12;
  localparam logic [3:0] S_HARD  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // control registers
  logic        limiter_enable;
  logic [15:0] peak_scale;
  logic [15:0] threshold_level;
  logic [15:0] ceiling_level;
  logic [15:0] attack_coef;
  logic [15:0] release_coef;

  // long-lived state
  logic [16:0] envelope;
  logic [16:0] smoothed_gain;
  logic [31:0] clip_counter;

  // per-word working registers
  logic [3:0]    state;
  logic          neg;
  logic [SB-1:0] mag;
  logic [MA-1:0] m;
  logic [16:0]   level;
  logic [15:0]   coef;
  logic [AW-1:0] acc;
  logic [18:0]   limit;
  logic [17:0]   rem;
  logic [15:0]   quot;
  logic [3:0]    div_cnt;
  logic [16:0]   target;
  logic [SB+1:0] hard;

  // output register
  logic                   out_valid;
  logic signed [SB-1:0]   out_sample;
  logic                   out_clipped;

  // shared multiplier
  logic [MA-1:0] mul_a;
  logic [16:0]   mul_b;
  logic [MW-1:0] prod;
  logic [15:0]   coef_sel;

  always_comb begin
    coef_sel = attack_coef;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_MAG: begin
        mul_a = MA'(mag);
        mul_b = {1'b0, peak_scale};
      end
      S_ENV0: begin
        coef_sel = (level > envelope) ? attack_coef : release_coef;
        mul_a    = MA'(level);
        mul_b    = UNITY_Q16 - {1'b0, coef_sel};
      end
      S_ENV1: begin
        mul_a = MA'(envelope);
        mul_b = {1'b0, coef};
      end
      S_LIM: begin
        mul_a = MA'(threshold_level);
        mul_b = {1'b0, peak_scale};
      end
      S_G0: begin
        coef_sel = (target < smoothed_gain) ? attack_coef : release_coef;
        mul_a    = MA'(target);
        mul_b    = UNITY_Q16 - {1'b0, coef_sel};
      end
      S_G1: begin
        mul_a = MA'(smoothed_gain);
        mul_b = {1'b0, coef};
      end
      S_APPLY: begin
        mul_a = m;
        mul_b = smoothed_gain;
      end
      S_HARD: begin
        mul_a = MA'(ceiling_level);
        mul_b = {1'b0, peak_scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = MW'(mul_a) * MW'(mul_b);

  // rounded shifts of the product and accumulator
  logic [MW:0]   prod_r15;
  logic [MW:0]   prod_r14;
  logic [MW:0]   prod_r16;
  logic [AW:0]   acc_r16;
  logic [QW-1:0] lv_w;
  logic [16:0]   lv_sat;
  logic [HW-1:0] hard_w;
  logic [17:0]   rem_sh;

  assign prod_r15 = ({1'b0, prod} + (MW+1)'(1 << 14)) >> 15;
  assign prod_r14 = ({1'b0, prod} + (MW+1)'(1 << 13)) >> 14;
  assign prod_r16 = ({1'b0, prod} + (MW+1)'(1 << 15)) >> 16;
  assign acc_r16  = ({1'b0, acc} + (AW+1)'(1 << 15)) >> 16;
  assign lv_w     = ((QW'(m) << QL) + QRND) >> QR;
  assign lv_sat   = (lv_w > QW'(MAX17)) ? MAX17 : lv_w[16:0];
  assign hard_w   = ((HW'(prod) << HL) + HRND) >> HR;
  assign rem_sh   = {rem[16:0], 1'b0};

  // final clamp, ceiling first then the sample range
  logic [CW-1:0] m_c;
  logic [CW-1:0] hard_c;
  logic [CW-1:0] lim_max;
  logic [CW-1:0] m_h;
  logic [CW-1:0] m_f;
  logic          clip;
  logic [SB-1:0] out_mag;

  always_comb begin
    m_c     = CW'(m);
    hard_c  = CW'(hard);
    lim_max = neg ? (CW'(1) << (SB - 1)) : ((CW'(1) << (SB - 1)) - CW'(1));
    clip    = 1'b0;
    m_h     = m_c;
    if (m_c > hard_c) begin
      m_h  = hard_c;
      clip = 1'b1;
    end
    m_f = m_h;
    if (m_h > lim_max) begin
      m_f  = lim_max;
      clip = 1'b1;
    end
    out_mag = neg ? SB'(-m_f) : SB'(m_f);
  end

  logic out_free;
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.clipped    = out_clipped;
  assign out_ch.clip_count = clip_counter;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_enable  <= 1'b1;
      peak_scale      <= RST_PEAK_SCALE;
      threshold_level <= RST_THRESHOLD;
      ceiling_level   <= RST_CEILING;
      attack_coef     <= RST_ATTACK_COEF;
      release_coef    <= RST_RELEASE_COEF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMITER_ENABLE:  limiter_enable  <= cfg_data[0];
        REG_PEAK_SCALE:      peak_scale      <= cfg_data;
        REG_THRESHOLD_LEVEL: threshold_level <= cfg_data;
        REG_CEILING_LEVEL:   ceiling_level   <= cfg_data;
        REG_ATTACK_COEF:     attack_coef     <= cfg_data;
        REG_RELEASE_COEF:    release_coef    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      envelope      <= '0;
      smoothed_gain <= UNITY_Q16;
      clip_counter  <= '0;
      out_valid     <= 1'b0;
    end else begin
      // output word loads from the sequencer or drains to the receiver
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            neg   <= in_ch.sample_in[SB-1];
            mag   <= in_ch.sample_in[SB-1] ? SB'(-in_ch.sample_in) : in_ch.sample_in;
            state <= S_MAG;
          end
        end
        S_MAG: begin
          m     <= MA'(prod_r15);
          state <= limiter_enable ? S_LEVEL : S_HARD;
        end
        S_LEVEL: begin
          level <= lv_sat;
          state <= S_ENV0;
        end
        S_ENV0: begin
          coef  <= coef_sel;
          acc   <= AW'(prod);
          state <= S_ENV1;
        end
        S_ENV1: begin
          acc   <= acc + AW'(prod);
          state <= S_ENV2;
        end
        S_ENV2: begin
          envelope <= acc_r16[16:0];
          state    <= S_LIM;
        end
        S_LIM: begin
          limit <= 19'(prod_r14);
          state <= S_CMP;
        end
        S_CMP: begin
          if ((19'(envelope) > limit) && (envelope > FLOOR_Q16)) begin
            rem     <= limit[17:0];
            quot    <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            target <= UNITY_Q16;
            state  <= S_G0;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem_sh >= {1'b0, envelope}) begin
            rem  <= rem_sh - {1'b0, envelope};
            quot <= {quot[14:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            // target taken from the divider as it finishes
            target <= {1'b0, quot[14:0], (rem_sh >= {1'b0, envelope})};
            state  <= S_G0;
          end
        end
        S_G0: begin
          coef  <= coef_sel;
          acc   <= AW'(prod);
          state <= S_G1;
        end
        S_G1: begin
          acc   <= acc + AW'(prod);
          state <= S_G2;
        end
        S_G2: begin
          smoothed_gain <= acc_r16[16:0];
          state         <= S_APPLY;
        end
        S_APPLY: begin
          m     <= MA'(prod_r16);
          state <= S_HARD;
        end
        S_HARD: begin
          hard  <= (SB+2)'(hard_w);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_sample  <= out_mag;
            out_clipped <= clip;
            if (clip && (clip_counter != 32'hFFFF_FFFF)) begin
              clip_counter <= clip_counter + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/apl_checker.sv
// ----------------------------------------------------------------------------
// apl_checker
// port-level checks on the audio peak limiter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module apl_checker #(
  parameter int SAMPLE_BITS = apl_pkg::DEF_SAMPLE_BITS
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [SAMPLE_BITS-1:0] sample_out,
  input wire                   clipped,
  input wire [31:0]            clip_count
);

  // after taking a word the sequencer is busy and does not take the next one at once
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("accepted a word while still busy");

  // a clamped result is always counted
  a_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (clip_count != 32'd0))
    else $error("clamp flagged with zero count");

  // after reset the block is empty and idle
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("not empty after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(clipped)))
    else $error("stalled result changed");

endmodule

bind audio_peak_limiter_top apl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_apl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .clipped    (out_ch.clipped),
  .clip_count (out_ch.clip_count)
);

`default_nettype wire

>>> tb/tb_audio_peak_limiter_top.sv
// ----------------------------------------------------------------------------
// tb_audio_peak_limiter_top
// drives sample words through the peak limiter under several register
// settings, predicts envelope, gain, clamp and clamp count per word and
// compares every result word field by field, with random gaps on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_peak_limiter_top;
  import apl_pkg::*;

  localparam int SB = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // indexes past the register list
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [SB-1:0] sample_out;
    logic                 clipped;
    logic [31:0]          clip_count;
  } limiter_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  apl_in_if #(.SAMPLE_BITS(SB)) in_ch ();
  apl_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  audio_peak_limiter_top #(.SAMPLE_BITS(SB)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and state
  logic        p_enable;
  logic [15:0] p_scale, p_thresh, p_ceil, p_attack, p_release;
  logic [16:0] p_env, p_gain;
  logic [31:0] p_clips;

  limiter_word_t expected_words[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit stim_done = 1'b0;
  bit rx_stall_free = 1'b0;

  function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [16:0] one_pole(logic [16:0] tgt, logic [16:0] cur,
                                           logic [15:0] c);
    logic [63:0] acc;
    acc = 64'(tgt) * (64'd65536 - 64'(c)) + 64'(cur) * 64'(c);
    return 17'(round_shift(acc, 16));
  endfunction

  // work out the result word for one sample, advancing predictor state
  function automatic limiter_word_t limit_sample(logic signed [SB-1:0] x);
    limiter_word_t r;
    logic        neg;
    logic [63:0] mag, m, lv, lim, hard, top;
    logic [16:0] level, tgt;
    logic [15:0] c;
    logic        clip;
    neg = x[SB-1];
    mag = neg ? 64'(-65'(x)) : 64'(x);
    m = round_shift(mag * 64'(p_scale), 15);
    clip = 1'b0;
    if (p_enable) begin
      lv = m << 1;
      level = (lv > 64'(MAX17)) ? MAX17 : 17'(lv);
      c = (level > p_env) ? p_attack : p_release;
      p_env = one_pole(level, p_env, c);
      lim = round_shift(64'(p_thresh) * 64'(p_scale), 14);
      tgt = UNITY_Q16;
      if (64'(p_env) > lim && p_env > FLOOR_Q16)
        tgt = 17'((lim << 16) / 64'(p_env));
      c = (tgt < p_gain) ? p_attack : p_release;
      p_gain = one_pole(tgt, p_gain, c);
      m = round_shift(m * 64'(p_gain), 16);
    end
    hard = round_shift(64'(p_ceil) * 64'(p_scale), 15);
    if (m > hard) begin
      m = hard;
      clip = 1'b1;
    end
    top = neg ? 64'd32768 : 64'd32767;
    if (m > top) begin
      m = top;
      clip = 1'b1;
    end
    if (clip && p_clips != 32'hFFFF_FFFF) p_clips++;
    r.sample_out = neg ? SB'(-m) : SB'(m);
    r.clipped = clip;
    r.clip_count = p_clips;
    return r;
  endfunction

  // register write; only while nothing is in flight, caller drops cfg_we
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_LIMITER_ENABLE:  p_enable = val[0];
      REG_PEAK_SCALE:      p_scale = val;
      REG_THRESHOLD_LEVEL: p_thresh = val;
      REG_CEILING_LEVEL:   p_ceil = val;
      REG_ATTACK_COEF:     p_attack = val;
      REG_RELEASE_COEF:    p_release = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(logic en, logic [15:0] sc, logic [15:0] th, logic [15:0] ce,
                         logic [15:0] at, logic [15:0] re);
    drain();
    write_reg(REG_LIMITER_ENABLE, {15'd0, en});
    write_reg(REG_PEAK_SCALE, sc);
    write_reg(REG_THRESHOLD_LEVEL, th);
    write_reg(REG_CEILING_LEVEL, ce);
    write_reg(REG_ATTACK_COEF, at);
    write_reg(REG_RELEASE_COEF, re);
    cfg_we <= 1'b0;
  endtask

  // send one sample word, with a random gap first
  task automatic send_sample(logic signed [SB-1:0] x);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(limit_sample(x));
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return SB'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF - SB'($urandom_range(0, 200))
                                     : 16'sh8000 + SB'($urandom_range(0, 200));
      2: return SB'($signed(10'($urandom)));
      default: return SB'($urandom) >>> $urandom_range(0, 8);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [SB-1:0] vals[9] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001,
                                      16'shFFFF, 16'sh8001, 16'sh4000, 16'shC000,
                                      16'sh5555};
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  // low threshold and ceiling: limiting and clamping, plus bypass path
  task automatic test_directed_settings();
    set_all(1'b1, 16'd32768, 16'd327, 16'd1638, 16'd0, 16'd65535);
    test_extremes();
    set_all(1'b0, 16'd0, 16'd32768, 16'd32768, 16'd65535, 16'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    // out-of-range scale saturates the sample range
    set_all(1'b0, 16'd65535, 16'd32768, 16'd32768, 16'd0, 16'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0100);
    // unknown index is dropped
    drain();
    write_reg(REG_SPARE_7, 16'hFFFF);
    write_reg(REG_SPARE_6, 16'h0000);
    cfg_we <= 1'b0;
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      set_all(1'($urandom_range(0, 3) != 0), 16'($urandom_range(0, 32768)),
              16'($urandom_range(327, 32768)), 16'($urandom_range(1638, 32768)),
              16'($urandom), 16'($urandom));
      rx_stall_free = (ph % 4 == 3);
      for (int i = 0; i < 50; i++) send_sample(rand_sample());
      // pause until every result is back
      if (ph == 5) drain();
    end
    rx_stall_free = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    p_enable = 1'b1;
    p_scale = RST_PEAK_SCALE;
    p_thresh = RST_THRESHOLD;
    p_ceil = RST_CEILING;
    p_attack = RST_ATTACK_COEF;
    p_release = RST_RELEASE_COEF;
    p_env = '0;
    p_gain = UNITY_Q16;
    p_clips = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_directed_settings();
    test_random_phases();
    drain();
    stim_done = 1'b1;
  end

  // receiver: random wait per word (none in stall-free phases), check each accepted word
  always @(posedge clk) begin
    limiter_word_t got, want;
    int nw;
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      nw = rx_wait;
      if (out_ch.valid && out_ch.ready) begin
        got.sample_out = out_ch.sample_out;
        got.clipped = out_ch.clipped;
        got.clip_count = out_ch.clip_count;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
          end
        end
        nw = rx_stall_free ? 0 : $urandom_range(0, 10);
      end else if (nw != 0) begin
        nw = nw - 1;
      end
      rx_wait <= nw;
      out_ch.ready <= (nw == 0);
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else if (stim_done) begin
      if (mismatches == 0 && expected_words.size() == 0)
        $display("PASSED: all results match");
      else
        $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
